FILE: src/ffcrc_pkg.sv
// Shared types, constants and the CRC16-CCITT-FALSE byte update for the
// fixed frame receiver. No dependencies; all files but the interfaces import it.

package ffcrc_pkg;

	// Frame length in bytes, counting the two-byte start word.
	localparam int FRAME_BYTES = 64;
	localparam int POS_W = 7;
	localparam int ADDR_W = 3;

	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_HUNT     = pos_t'(0);
	localparam pos_t POS_START_HI = pos_t'(1);
	localparam pos_t POS_VERSION  = pos_t'(2);
	localparam pos_t POS_CK_LO    = pos_t'(FRAME_BYTES - 2);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [15:0] START_WORD_RESET       = 16'hABCD;
	localparam logic [7:0]  EXPECTED_VERSION_RESET = 8'h01;

	// Register index codes, taken from paddr[2].
	localparam logic REG_START_WORD       = 1'b0;
	localparam logic REG_EXPECTED_VERSION = 1'b1;

	typedef struct packed {
		logic [15:0] start_word;
		logic [7:0]  expected_version;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [5:0]  byte_position;
		logic        end_of_frame;
		logic        frame_good;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} result_t;

	// One byte of CRC16-CCITT-FALSE, MSB first, no reflection.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: src/ffcrc_in_if.sv
// Valid/ready channel that carries one received byte per word.
// No dependencies.

interface ffcrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

FILE: src/ffcrc_out_if.sv
// Valid/ready channel that carries one passed-through frame byte per word
// with its position, verdict and the frame counters. No dependencies.

interface ffcrc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_byte;
	logic [5:0]  byte_position;
	logic        end_of_frame;
	logic        frame_good;
	logic [31:0] good_frames;
	logic [31:0] bad_frames;

	modport source(output valid, output frame_byte, output byte_position,
		output end_of_frame, output frame_good, output good_frames,
		output bad_frames, input ready);
	modport sink(input valid, input frame_byte, input byte_position,
		input end_of_frame, input frame_good, input good_frames,
		input bad_frames, output ready);
endinterface

FILE: src/ffcrc_cfg.sv
// APB-style register file holding the start word and expected version.
// Depends on ffcrc_pkg.

module ffcrc_cfg import ffcrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_word       <= START_WORD_RESET;
			cfg_q.expected_version <= EXPECTED_VERSION_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_START_WORD: begin
					cfg_q.start_word <= pwdata[15:0];
				end
				REG_EXPECTED_VERSION: begin
					cfg_q.expected_version <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START_WORD:       prdata = {16'h0000, cfg_q.start_word};
			REG_EXPECTED_VERSION: prdata = {24'h000000, cfg_q.expected_version};
			default:              prdata = 32'h0000_0000;
		endcase
	end

endmodule

FILE: src/ffcrc_frame.sv
// Frame tracker: start-word hunt, position count, running CRC, version
// check and good/bad counters. One byte per step. Depends on ffcrc_pkg.

module ffcrc_frame import ffcrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       produce,
	output result_t    res
);

	pos_t        pos_q, pos_n;
	logic [15:0] crc_q, crc_n;
	logic        ver_q, ver_n;
	logic [7:0]  cklo_q, cklo_n;
	logic [31:0] good_q, good_n;
	logic [31:0] bad_q, bad_n;
	logic [7:0]  lo, hi;
	logic [15:0] crc_upd;
	logic        last, good;

	assign lo = cfg.start_word[7:0];
	assign hi = cfg.start_word[15:8];

	// On the high start byte the CRC restarts from the low start byte as it
	// is configured now, so a register write during the hunt is honored.
	assign crc_upd = crc_byte((pos_q == POS_START_HI) ? crc_byte(CRC_INIT, lo) : crc_q,
		rx_byte);

	always_comb begin
		pos_n   = pos_q;
		crc_n   = crc_q;
		ver_n   = ver_q;
		cklo_n  = cklo_q;
		good_n  = good_q;
		bad_n   = bad_q;
		produce = 1'b0;
		last    = 1'b0;
		good    = 1'b0;
		if (pos_q == POS_HUNT) begin
			if (rx_byte == lo) begin
				pos_n = POS_START_HI;
			end
		end else if (pos_q == POS_START_HI) begin
			if (rx_byte == hi) begin
				crc_n = crc_upd;
				ver_n = 1'b0;
				pos_n = POS_VERSION;
			end else if (rx_byte != lo) begin
				pos_n = POS_HUNT;
			end
		end else begin
			produce = 1'b1;
			if (pos_q == POS_VERSION) begin
				ver_n = (rx_byte == cfg.expected_version);
			end
			if (pos_q < POS_CK_LO) begin
				crc_n = crc_upd;
				pos_n = pos_q + pos_t'(1);
			end else if (pos_q == POS_CK_LO) begin
				cklo_n = rx_byte;
				pos_n  = pos_q + pos_t'(1);
			end else begin
				last = 1'b1;
				good = ver_n && ({rx_byte, cklo_q} == crc_q);
				if (good) begin
					good_n = good_q + 32'd1;
				end else begin
					bad_n = bad_q + 32'd1;
				end
				pos_n = POS_HUNT;
				crc_n = CRC_INIT;
			end
		end
	end

	always_comb begin
		res.frame_byte    = rx_byte;
		res.byte_position = pos_q[5:0];
		res.end_of_frame  = last;
		res.frame_good    = good;
		res.good_frames   = good_n;
		res.bad_frames    = bad_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			crc_q  <= CRC_INIT;
			ver_q  <= 1'b0;
			cklo_q <= 8'h00;
			good_q <= 32'd0;
			bad_q  <= 32'd0;
		end else if (step) begin
			pos_q  <= pos_n;
			crc_q  <= crc_n;
			ver_q  <= ver_n;
			cklo_q <= cklo_n;
			good_q <= good_n;
			bad_q  <= bad_n;
		end
	end

endmodule

FILE: src/fixed_frame_crc16_receiver_core.sv
// Top level of the fixed frame CRC16 receiver: input register, frame
// tracker, result register and APB register file. Depends on ffcrc_pkg,
// ffcrc_in_if, ffcrc_out_if, ffcrc_cfg and ffcrc_frame.
//
// Usage: received bytes enter one word at a time on rx_in. The block hunts
// for the start word (low byte first), then passes every further byte of the
// frame out on frame_out with its offset, an end-of-frame flag, the verdict
// on the last byte (version and CRC16-CCITT-FALSE matched) and the good and
// bad frame counters. Start word bytes and bytes outside a frame give no
// output word.
// Path: each byte passes the input register, and a byte that yields an output
// word then passes the output register.
// Throughput: one byte per cycle unless frame_out stalls; the CRC update is
// one combinational byte-wide step between the two registers.
// Reset: arst_n resets the hunt and CRC, clears the counters and the valid
// flags of both registers, and loads start word 0xABCD, expected version 1.
// Stall: when frame_out is not taken, the output word holds and the input
// register keeps one more byte; rx_in.ready then drops until space frees up.
// Users write registers over APB only while the block is idle; not enforced.

module fixed_frame_crc16_receiver_core import ffcrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ffcrc_in_if.sink          rx_in,
	ffcrc_out_if.source       frame_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t    cfg;
	logic    v_s1;
	logic [7:0] byte_s1;
	logic    v_s2;
	result_t res_s2;
	result_t res;
	logic    produce;
	logic    s1_adv;
	logic    s2_free;

	ffcrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ffcrc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_adv),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.produce (produce),
		.res     (res)
	);

	assign s2_free     = !v_s2 || frame_out.ready;
	// A byte that yields no output word moves on even while the output stalls.
	assign s1_adv      = v_s1 && (!produce || s2_free);
	assign rx_in.ready = !v_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			v_s1 <= rx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_in.ready && rx_in.valid) begin
			byte_s1 <= rx_in.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_adv && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && produce) begin
			res_s2 <= res;
		end
	end

	assign frame_out.valid         = v_s2;
	assign frame_out.frame_byte    = res_s2.frame_byte;
	assign frame_out.byte_position = res_s2.byte_position;
	assign frame_out.end_of_frame  = res_s2.end_of_frame;
	assign frame_out.frame_good    = res_s2.frame_good;
	assign frame_out.good_frames   = res_s2.good_frames;
	assign frame_out.bad_frames    = res_s2.bad_frames;

endmodule

FILE: tb/fixed_frame_crc16_receiver_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_frame_crc16_receiver_core: drives bytes and APB
// register writes, predicts every frame word and compares. Depends on ffcrc_pkg,
// ffcrc_in_if, ffcrc_out_if and the receiver RTL.

module fixed_frame_crc16_receiver_core_tb;
	import ffcrc_pkg::*;

	typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_VER, FR_SHORT} frame_kind_e;

	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_BYTES_PER_PHASE = 160;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	ffcrc_in_if  rx_in();
	ffcrc_out_if frame_out();

	fixed_frame_crc16_receiver_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_in(rx_in),
		.frame_out(frame_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predicted receiver state and the testbench copy of the registers.
	logic [15:0] cfg_start_word;
	logic [7:0]  cfg_version;
	pos_t        trk_pos;
	logic [15:0] trk_crc;
	logic        trk_version_ok;
	logic [7:0]  trk_ck_lo;
	logic [31:0] trk_good;
	logic [31:0] trk_bad;

	result_t pending_words[$];
	logic [7:0] fbytes[FRAME_BYTES];

	int err_count = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		int          i;
		r = c;
		for (i = 7; i >= 0; i--) begin
			fb = r[15] ^ d[i];
			r = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		// Keep the log short when the block is badly broken.
		if (err_count <= 50) begin
			$display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
		end
	endtask

	// Advances the predicted state by one accepted byte and queues the word it yields.
	task automatic track_rx_byte(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		result_t    r;
		lo = cfg_start_word[7:0];
		hi = cfg_start_word[15:8];
		if (trk_pos == POS_HUNT) begin
			if (b == lo) begin
				trk_pos = POS_START_HI;
			end
			return;
		end
		if (trk_pos == POS_START_HI) begin
			// The high byte wins, so a start word with equal bytes still completes.
			if (b == hi) begin
				trk_crc = crc16_ccitt_byte(crc16_ccitt_byte(CRC_INIT, lo), b);
				trk_version_ok = 1'b0;
				trk_pos = POS_VERSION;
			end else if (b != lo) begin
				trk_pos = POS_HUNT;
			end
			return;
		end
		r.frame_byte = b;
		r.byte_position = trk_pos[5:0];
		r.end_of_frame = 1'b0;
		r.frame_good = 1'b0;
		if (trk_pos == POS_VERSION) begin
			trk_version_ok = (b == cfg_version);
		end
		if (trk_pos < POS_CK_LO) begin
			trk_crc = crc16_ccitt_byte(trk_crc, b);
			trk_pos = trk_pos + pos_t'(1);
		end else if (trk_pos == POS_CK_LO) begin
			trk_ck_lo = b;
			trk_pos = trk_pos + pos_t'(1);
		end else begin
			r.end_of_frame = 1'b1;
			r.frame_good = trk_version_ok && ({b, trk_ck_lo} == trk_crc);
			if (r.frame_good) begin
				trk_good = trk_good + 32'd1;
			end else begin
				trk_bad = trk_bad + 32'd1;
			end
			trk_pos = POS_HUNT;
			trk_crc = CRC_INIT;
		end
		r.good_frames = trk_good;
		r.bad_frames = trk_bad;
		pending_words.push_back(r);
	endtask

	// Called at a rising edge; returns at the edge that accepts the byte with valid still high.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_in.valid <= 1'b0;
			@(posedge clk);
		end
		rx_in.valid <= 1'b1;
		rx_in.rx_byte <= b;
		@(posedge clk);
		while (!rx_in.ready) begin
			@(posedge clk);
		end
		bytes_sent++;
		track_rx_byte(b);
	endtask

	task automatic wait_idle();
		rx_in.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_words.size() != 0);
		// Start word bytes give no output word but may still sit in the pipeline.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_START_WORD) begin
			cfg_start_word = data[15:0];
		end else begin
			cfg_version = data[7:0];
		end
	endtask

	task automatic apb_read_check(input logic idx, input logic [31:0] want);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_START_WORD) begin
			if (got[15:0] !== want[15:0]) begin
				report_mismatch("start_word read", got, want);
			end
		end else if (got[7:0] !== want[7:0]) begin
			report_mismatch("expected_version read", got, want);
		end
	endtask

	task automatic set_config(input logic [15:0] sw, input logic [7:0] ver);
		wait_idle();
		apb_write(REG_START_WORD, {16'h0000, sw});
		apb_write(REG_EXPECTED_VERSION, {24'h000000, ver});
		apb_read_check(REG_START_WORD, {16'h0000, sw});
		apb_read_check(REG_EXPECTED_VERSION, {24'h000000, ver});
	endtask

	// Fills fbytes with one frame for the current registers.
	task automatic build_frame(input frame_kind_e kind);
		logic [15:0] c;
		int          i;
		int          idx;
		fbytes[0] = cfg_start_word[7:0];
		fbytes[1] = cfg_start_word[15:8];
		fbytes[2] = cfg_version;
		if (kind == FR_BAD_VER) begin
			fbytes[2] = cfg_version ^ 8'($urandom_range(1, 255));
		end
		for (i = 3; i < FRAME_BYTES - 2; i++) begin
			if ($urandom_range(7) == 0) begin
				fbytes[i] = $urandom_range(1) ? 8'hFF : 8'h00;
			end else begin
				fbytes[i] = 8'($urandom_range(255));
			end
		end
		c = CRC_INIT;
		for (i = 0; i < FRAME_BYTES - 2; i++) begin
			c = crc16_ccitt_byte(c, fbytes[i]);
		end
		fbytes[FRAME_BYTES - 2] = c[7:0];
		fbytes[FRAME_BYTES - 1] = c[15:8];
		if (kind == FR_BAD_CRC) begin
			idx = $urandom_range(3, FRAME_BYTES - 1);
			fbytes[idx] = fbytes[idx] ^ 8'(1 << $urandom_range(7));
		end
	endtask

	task automatic send_span(input int first, input int last);
		int i;
		for (i = first; i <= last; i++) begin
			send_byte(fbytes[i]);
		end
	endtask

	task automatic send_noise(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic test_reset_state();
		apb_read_check(REG_START_WORD, {16'h0000, START_WORD_RESET});
		apb_read_check(REG_EXPECTED_VERSION, {24'h000000, EXPECTED_VERSION_RESET});
		build_frame(FR_GOOD);
		send_span(0, FRAME_BYTES - 1);
	endtask

	task automatic test_start_hunt();
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] other;
		lo = cfg_start_word[7:0];
		hi = cfg_start_word[15:8];
		other = 8'h00;
		while (other == lo || other == hi) begin
			other = other + 8'd1;
		end
		// A stray byte after the low start byte drops the hunt back to the beginning.
		send_byte(lo);
		send_byte(other);
		send_byte(hi);
		// Repeated low start bytes keep waiting for the high byte.
		send_byte(lo);
		send_byte(lo);
		build_frame(FR_GOOD);
		send_span(0, FRAME_BYTES - 1);
		build_frame(FR_BAD_CRC);
		send_span(0, FRAME_BYTES - 1);
	endtask

	task automatic test_config_extremes();
		set_config(16'h0000, 8'h00);
		build_frame(FR_GOOD);
		send_span(0, FRAME_BYTES - 1);
		set_config(16'hFFFF, 8'hFF);
		// An extra leading 0xFF: the high byte test completes the start word first.
		send_byte(8'hFF);
		build_frame(FR_GOOD);
		send_span(0, FRAME_BYTES - 1);
		build_frame(FR_BAD_VER);
		send_span(0, FRAME_BYTES - 1);
	endtask

	task automatic test_mid_frame_writes();
		set_config(16'hABCD, 8'h01);
		// Change the high start byte while the hunt waits for it.
		send_byte(8'hCD);
		wait_idle();
		apb_write(REG_START_WORD, 32'h0000_12CD);
		build_frame(FR_GOOD);
		send_span(1, FRAME_BYTES - 1);
		// Change the version just before the version byte arrives.
		build_frame(FR_GOOD);
		send_span(0, 1);
		wait_idle();
		apb_write(REG_EXPECTED_VERSION, 32'h0000_007E);
		build_frame(FR_GOOD);
		send_span(2, FRAME_BYTES - 1);
		// A version change after the version byte leaves the verdict alone.
		build_frame(FR_GOOD);
		send_span(0, 20);
		wait_idle();
		apb_write(REG_EXPECTED_VERSION, 32'h0000_0001);
		send_span(21, FRAME_BYTES - 1);
	endtask

	task automatic test_output_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
		hold_left <= HOLD_OFF_CYCLES;
		build_frame(FR_GOOD);
		send_span(0, FRAME_BYTES - 1);
		// Let every word drain before anything else is offered.
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int          send_pcts[4] = '{0, 71, 0, 23};
		int          recv_pcts[4] = '{0, 0, 71, 23};
		int          ph;
		int          pick;
		int          target;
		logic [15:0] sw;
		frame_kind_e kind;
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			if (ph == 1) begin
				sw = 16'h0000;
			end else if (ph == 3) begin
				sw = 16'hFFFF;
			end else begin
				sw = 16'($urandom_range(65535));
			end
			set_config(sw, 8'($urandom_range(255)));
			target = bytes_sent + RANDOM_BYTES_PER_PHASE;
			while (bytes_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					send_noise($urandom_range(1, 8));
				end else begin
					if (pick < 60) begin
						kind = FR_GOOD;
					end else if (pick < 75) begin
						kind = FR_BAD_CRC;
					end else if (pick < 88) begin
						kind = FR_BAD_VER;
					end else begin
						kind = FR_SHORT;
					end
					build_frame(kind);
					if (kind == FR_SHORT) begin
						send_span(0, $urandom_range(3, FRAME_BYTES - 2));
					end else begin
						send_span(0, FRAME_BYTES - 1);
					end
				end
			end
		end
	endtask

	// Output side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			frame_out.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			frame_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && frame_out.valid === 1'b1 && frame_out.ready === 1'b1) begin
			got.frame_byte = frame_out.frame_byte;
			got.byte_position = frame_out.byte_position;
			got.end_of_frame = frame_out.end_of_frame;
			got.frame_good = frame_out.frame_good;
			got.good_frames = frame_out.good_frames;
			got.bad_frames = frame_out.bad_frames;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word, frame_byte", 32'(got.frame_byte), 32'd0);
			end else begin
				want = pending_words.pop_front();
				if (got.frame_byte !== want.frame_byte)
					report_mismatch("frame_byte", 32'(got.frame_byte),
						32'(want.frame_byte));
				if (got.byte_position !== want.byte_position)
					report_mismatch("byte_position", 32'(got.byte_position),
						32'(want.byte_position));
				if (got.end_of_frame !== want.end_of_frame)
					report_mismatch("end_of_frame", 32'(got.end_of_frame),
						32'(want.end_of_frame));
				if (got.frame_good !== want.frame_good)
					report_mismatch("frame_good", 32'(got.frame_good),
						32'(want.frame_good));
				if (got.good_frames !== want.good_frames)
					report_mismatch("good_frames", got.good_frames, want.good_frames);
				if (got.bad_frames !== want.bad_frames)
					report_mismatch("bad_frames", got.bad_frames, want.bad_frames);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("fixed_frame_crc16_receiver_core test failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_in.valid = 1'b0;
		rx_in.rx_byte = 8'h00;
		frame_out.ready = 1'b0;
		cfg_start_word = START_WORD_RESET;
		cfg_version = EXPECTED_VERSION_RESET;
		trk_pos = POS_HUNT;
		trk_crc = CRC_INIT;
		trk_version_ok = 1'b0;
		trk_ck_lo = 8'h00;
		trk_good = '0;
		trk_bad = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_start_hunt();
		test_config_extremes();
		test_mid_frame_writes();
		test_output_hold_off();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_words.size() == 0) begin
			$display("fixed_frame_crc16_receiver_core test passed");
		end else begin
			$display("fixed_frame_crc16_receiver_core test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/ffcrc_pkg.sv
src/ffcrc_in_if.sv
src/ffcrc_out_if.sv
src/ffcrc_cfg.sv
src/ffcrc_frame.sv
src/fixed_frame_crc16_receiver_core.sv
tb/fixed_frame_crc16_receiver_core_tb.sv
